[sv/ctli_pkg.sv]
package ctli_pkg;

    localparam int ALT_W = 16;
    localparam int VAL_W = 32;
    localparam int QRY_W = 17;
    localparam int CNT_W = 6;
    localparam int CFG_W = 16;
    localparam int DX_W  = ALT_W + 1;
    localparam int DY_W  = VAL_W + 1;
    localparam int PRD_W = DX_W + DY_W;
    localparam int MAG_W = PRD_W - 1;
    localparam int SUM_W = PRD_W + 1;

    localparam logic REG_MAX_ALT   = 1'b0;
    localparam logic REG_ROW_COUNT = 1'b1;

    typedef struct packed {
        logic signed [VAL_W-1:0] y_lo;
        logic signed [VAL_W-1:0] y_hi;
        logic                    direct;
        logic                    exact;
        logic                    nonempty;
        logic                    neg;
    } ctli_tag_t;

endpackage

[sv/ctli_ram.sv]
module ctli_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/ctli_div.sv]
// Unsigned restoring divider, one quotient bit per stage.
module ctli_div import ctli_pkg::*; #(
    parameter int NW = 49,
    parameter int DW = 16,
    parameter int TW = 68
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [TW-1:0] out_tag
);

    logic          vld_reg [NW];
    logic [NW-1:0] nq_reg  [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [DW-1:0] den_reg [NW];
    logic [TW-1:0] tag_reg [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic          vld_in;
        logic [NW-1:0] nq_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [TW-1:0] tag_in;
        logic [DW:0]   r_ext;
        logic          take;
        logic [DW:0]   r_sub;

        if (k == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign nq_in  = in_num;
            assign rem_in = '0;
            assign den_in = in_den;
            assign tag_in = in_tag;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[k-1];
            assign nq_in  = nq_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        assign r_ext = {rem_in, nq_in[NW-1]};
        assign take  = r_ext >= {1'b0, den_in};
        assign r_sub = r_ext - {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            nq_reg[k]  <= {nq_in[NW-2:0], take};
            rem_reg[k] <= take ? r_sub[DW-1:0] : r_ext[DW-1:0];
            den_reg[k] <= den_in;
            tag_reg[k] <= tag_in;
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quo   = nq_reg[NW-1];
    assign out_tag   = tag_reg[NW-1];

endmodule

[sv/clamped_table_linear_interpolator_core.sv]
// Pipelined table lookup with linear interpolation.
// The 49-stage divider makes up most of the pipeline from start to done.
// Throughput: one transaction per cycle; busy is always low.
// Results come as one-cycle done strobes; the receiver cannot stall.
// Reset (rst_n low, async) clears pipeline valids and sets max_altitude 65535,
// row_count 0; table contents stay undefined until written.
module clamped_table_linear_interpolator_core import ctli_pkg::*; #(
    parameter int TABLE_ROWS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic                    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    start,
    output logic                    busy,
    input  logic                    func,
    input  logic [4:0]              row_index,
    input  logic [ALT_W-1:0]        row_altitude,
    input  logic signed [VAL_W-1:0] row_value,
    input  logic signed [QRY_W-1:0] query_altitude,
    output logic                    done,
    output logic signed [VAL_W-1:0] result_value,
    output logic                    result_valid,
    output logic                    exact_hit
);

    localparam int IW = $clog2(TABLE_ROWS);
    localparam logic [8:0] ROWS9 = 9'(TABLE_ROWS);
    localparam int TW = $bits(ctli_tag_t);

    logic [ALT_W-1:0] max_alt_reg;
    logic [CNT_W-1:0] row_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_alt_reg   <= '1;
            row_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_ALT:   max_alt_reg   <= cfg_data;
                REG_ROW_COUNT: row_count_reg <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic [8:0] n_rows;
    assign n_rows = ({3'b0, row_count_reg} > ROWS9) ? ROWS9 : {3'b0, row_count_reg};

    // stage 1: clamp and capture
    logic                    s1_vld_reg;
    logic                    s1_look_reg;
    logic [ALT_W-1:0]        s1_x_reg;
    logic                    s1_wok_reg;
    logic [IW-1:0]           s1_waddr_reg;
    logic [ALT_W-1:0]        s1_walt_reg;
    logic signed [VAL_W-1:0] s1_wval_reg;
    logic [ALT_W-1:0]        x_next;
    logic [8:0]              widx9;

    always_comb
    begin
        if (query_altitude[QRY_W-1])
        begin
            x_next = '0;
        end
        else if (query_altitude[ALT_W-1:0] > max_alt_reg)
        begin
            x_next = max_alt_reg;
        end
        else
        begin
            x_next = query_altitude[ALT_W-1:0];
        end
    end

    assign widx9 = {4'b0, row_index};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_look_reg  <= func;
        s1_x_reg     <= x_next;
        s1_wok_reg   <= widx9 < ROWS9;
        s1_waddr_reg <= widx9[IW-1:0];
        s1_walt_reg  <= row_altitude;
        s1_wval_reg  <= row_value;
    end

    // key copy for parallel compare
    logic [ALT_W-1:0] alt_reg [TABLE_ROWS];
    logic             s1_wr;
    assign s1_wr = s1_vld_reg && !s1_look_reg && s1_wok_reg;

    always_ff @(posedge clk)
    begin
        if (s1_wr)
        begin
            alt_reg[s1_waddr_reg] <= s1_walt_reg;
        end
    end

    logic [TABLE_ROWS-1:0] eq_vec;
    logic [TABLE_ROWS-1:0] ge_vec;

    for (genvar i = 0; i < TABLE_ROWS; i++)
    begin : g_cmp
        logic in_use;
        assign in_use    = 9'(i) < n_rows;
        assign eq_vec[i] = in_use && (alt_reg[i] == s1_x_reg);
        assign ge_vec[i] = in_use && (alt_reg[i] >= s1_x_reg);
    end

    // stage 2: search and table read
    logic                    s2_vld_reg;
    logic                    s2_look_reg;
    logic [ALT_W-1:0]        s2_x_reg;
    logic [TABLE_ROWS-1:0]   s2_eq_reg;
    logic [TABLE_ROWS-1:0]   s2_ge_reg;
    logic                    s2_empty_reg;
    logic [IW-1:0]           s2_last_reg;
    logic                    s2_wok_reg;
    logic [IW-1:0]           s2_waddr_reg;
    logic [ALT_W-1:0]        s2_walt_reg;
    logic signed [VAL_W-1:0] s2_wval_reg;
    logic [8:0]              n_last9;

    assign n_last9 = n_rows - 9'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_look_reg  <= s1_look_reg;
        s2_x_reg     <= s1_x_reg;
        s2_eq_reg    <= eq_vec;
        s2_ge_reg    <= ge_vec;
        s2_empty_reg <= n_rows == 9'd0;
        s2_last_reg  <= n_last9[IW-1:0];
        s2_wok_reg   <= s1_wok_reg;
        s2_waddr_reg <= s1_waddr_reg;
        s2_walt_reg  <= s1_walt_reg;
        s2_wval_reg  <= s1_wval_reg;
    end

    logic [IW-1:0] eq_idx;
    logic [IW-1:0] ge_idx;
    logic          eq_any;
    logic          ge_any;
    logic [IW-1:0] hi_idx;
    logic [IW-1:0] lo_idx;

    always_comb
    begin
        eq_idx = '0;
        ge_idx = '0;
        eq_any = 1'b0;
        ge_any = 1'b0;
        for (int i = TABLE_ROWS - 1; i >= 0; i--)
        begin
            if (s2_eq_reg[i])
            begin
                eq_idx = IW'(i);
                eq_any = 1'b1;
            end
            if (s2_ge_reg[i])
            begin
                ge_idx = IW'(i);
                ge_any = 1'b1;
            end
        end
        if (eq_any)
        begin
            hi_idx = eq_idx;
        end
        else if (ge_any)
        begin
            hi_idx = ge_idx;
        end
        else
        begin
            hi_idx = s2_last_reg;
        end
        lo_idx = (hi_idx == '0) ? '0 : hi_idx - IW'(1);
    end

    logic                         ram_we;
    logic [ALT_W+VAL_W-1:0]       ram_wdata;
    logic [ALT_W+VAL_W-1:0]       hi_data;
    logic [ALT_W+VAL_W-1:0]       lo_data;

    assign ram_we    = s2_vld_reg && !s2_look_reg && s2_wok_reg;
    assign ram_wdata = {s2_walt_reg, s2_wval_reg};

    ctli_ram #(.WIDTH(ALT_W + VAL_W), .DEPTH(TABLE_ROWS)) u_ram_hi (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s2_waddr_reg),
        .wdata (ram_wdata),
        .raddr (hi_idx),
        .rdata (hi_data)
    );

    ctli_ram #(.WIDTH(ALT_W + VAL_W), .DEPTH(TABLE_ROWS)) u_ram_lo (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s2_waddr_reg),
        .wdata (ram_wdata),
        .raddr (lo_idx),
        .rdata (lo_data)
    );

    // stage 3: row data available
    logic             s3_vld_reg;
    logic [ALT_W-1:0] s3_x_reg;
    logic             s3_exact_reg;
    logic             s3_empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg && s2_look_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_x_reg     <= s2_x_reg;
        s3_exact_reg <= eq_any;
        s3_empty_reg <= s2_empty_reg;
    end

    logic [ALT_W-1:0]        x_hi;
    logic [ALT_W-1:0]        x_lo;
    logic signed [VAL_W-1:0] y_hi;
    logic signed [VAL_W-1:0] y_lo;

    assign x_hi = hi_data[ALT_W+VAL_W-1:VAL_W];
    assign y_hi = hi_data[VAL_W-1:0];
    assign x_lo = lo_data[ALT_W+VAL_W-1:VAL_W];
    assign y_lo = lo_data[VAL_W-1:0];

    // stage 4: differences
    logic                    s4_vld_reg;
    logic signed [DX_W-1:0]  s4_dx_reg;
    logic signed [DX_W-1:0]  s4_den_reg;
    logic signed [DY_W-1:0]  s4_dy_reg;
    ctli_tag_t               s4_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_dx_reg           <= {1'b0, s3_x_reg} - {1'b0, x_lo};
        s4_den_reg          <= {1'b0, x_hi} - {1'b0, x_lo};
        s4_dy_reg           <= {y_hi[VAL_W-1], y_hi} - {y_lo[VAL_W-1], y_lo};
        s4_tag_reg.y_lo     <= y_lo;
        s4_tag_reg.y_hi     <= y_hi;
        s4_tag_reg.direct   <= s3_exact_reg || (x_hi == x_lo);
        s4_tag_reg.exact    <= s3_exact_reg;
        s4_tag_reg.nonempty <= !s3_empty_reg;
        s4_tag_reg.neg      <= 1'b0;
    end

    // stage 5: product
    logic                    s5_vld_reg;
    logic signed [PRD_W-1:0] s5_prod_reg;
    logic signed [DX_W-1:0]  s5_den_reg;
    ctli_tag_t               s5_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_prod_reg <= PRD_W'(s4_dx_reg) * PRD_W'(s4_dy_reg);
        s5_den_reg  <= s4_den_reg;
        s5_tag_reg  <= s4_tag_reg;
    end

    // stage 6: magnitudes
    logic                 s6_vld_reg;
    logic [MAG_W-1:0]     s6_num_reg;
    logic [ALT_W-1:0]     s6_den_reg;
    ctli_tag_t            s6_tag_reg;
    ctli_tag_t            s6_tag_next;
    logic [PRD_W-1:0]     prod_abs;
    logic [DX_W-1:0]      den_abs;

    assign prod_abs = s5_prod_reg[PRD_W-1] ? -s5_prod_reg : s5_prod_reg;
    assign den_abs  = s5_den_reg[DX_W-1] ? -s5_den_reg : s5_den_reg;

    always_comb
    begin
        s6_tag_next     = s5_tag_reg;
        s6_tag_next.neg = s5_prod_reg[PRD_W-1] ^ s5_den_reg[DX_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_vld_reg <= 1'b0;
        end
        else
        begin
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_num_reg <= prod_abs[MAG_W-1:0];
        s6_den_reg <= den_abs[ALT_W-1:0];
        s6_tag_reg <= s6_tag_next;
    end

    logic             dv_vld;
    logic [MAG_W-1:0] dv_quo;
    logic [TW-1:0]    dv_tag_bits;
    ctli_tag_t        dv_tag;

    ctli_div #(.NW(MAG_W), .DW(ALT_W), .TW(TW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_vld_reg),
        .in_num    (s6_num_reg),
        .in_den    (s6_den_reg),
        .in_tag    (s6_tag_reg),
        .out_valid (dv_vld),
        .out_quo   (dv_quo),
        .out_tag   (dv_tag_bits)
    );

    assign dv_tag = ctli_tag_t'(dv_tag_bits);

    // final: sum, saturate, select
    logic signed [PRD_W-1:0] quo_s;
    logic signed [SUM_W-1:0] sum;
    logic signed [VAL_W-1:0] sat;
    logic signed [VAL_W-1:0] value_next;

    always_comb
    begin
        quo_s = dv_tag.neg ? -{1'b0, dv_quo} : {1'b0, dv_quo};
        sum   = SUM_W'(dv_tag.y_lo) + SUM_W'(quo_s);
        if (sum[SUM_W-1:VAL_W-1] == '0 || sum[SUM_W-1:VAL_W-1] == '1)
        begin
            sat = sum[VAL_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
        if (!dv_tag.nonempty)
        begin
            value_next = '0;
        end
        else if (dv_tag.direct)
        begin
            value_next = dv_tag.y_hi;
        end
        else
        begin
            value_next = sat;
        end
    end

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_value <= value_next;
        result_valid <= dv_tag.nonempty;
        exact_hit    <= dv_tag.nonempty && dv_tag.exact;
    end

    assign done = done_reg;

endmodule
